// File: hw/rtl/encoder_velocity_pid_drive_core_defines.svh
// assertion macros for the speed regulator checker
`ifndef ENCODER_VELOCITY_PID_DRIVE_CORE_DEFINES_SVH
`define ENCODER_VELOCITY_PID_DRIVE_CORE_DEFINES_SVH

// checked only outside reset
`define EVPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define EVPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/evpd_pkg.sv
// constants and types shared by the speed regulator files
`timescale 1ns / 1ps
package evpd_pkg;

  localparam int ACTION_W    = 2;
  localparam int SPEED_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int LEVEL_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int WINDOW_MS   = 50;
  localparam int FRAC_BITS   = 8;
  localparam int GAIN_SHIFT  = 8;
  localparam int SPEED_SCALE = 6280;
  localparam int OUT_LIMIT   = 255 * (1 << FRAC_BITS);

  // integral scale 20 * 256 = 5 << 10, derivative scale 50000 * 256 = 3125 << 12
  localparam int RECIP_W      = 30;
  localparam int ISCALE_SHIFT = 10;
  localparam int IRECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] IRECIP = 30'd858993460;
  localparam int DSCALE_SHIFT = 12;
  localparam int DRECIP_SHIFT = 41;
  localparam logic [RECIP_W-1:0] DRECIP = 30'd703687442;

  localparam int DIV_NUM_W   = 53;
  localparam int DIV_DEN_W   = 48;

  localparam logic [ACTION_W-1:0] ACT_EDGE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CONTROL = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_REV = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSED      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D        = 3'd4;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [LEVEL_W-1:0]        level_t;

endpackage

// File: hw/rtl/evpd_if.sv
// item channels and configuration channel of the speed regulator
`timescale 1ns / 1ps
interface evpd_in_if;
  import evpd_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  logic    chan_a;
  logic    chan_b;
  speed_t  target_speed;
  modport source (output valid, action, chan_a, chan_b, target_speed, input ready);
  modport sink (input valid, action, chan_a, chan_b, target_speed, output ready);
endinterface

interface evpd_out_if;
  import evpd_pkg::*;
  logic   valid;
  logic   ready;
  level_t drive_level;
  logic   drive_dir;
  speed_t measured_speed;
  modport source (output valid, drive_level, drive_dir, measured_speed, input ready);
  modport sink (input valid, drive_level, drive_dir, measured_speed, output ready);
endinterface

interface evpd_cfg_if;
  import evpd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/encoder_velocity_pid_drive_core.sv
// Motor speed regulator with quadrature count, speed estimate and PID drive output.
// Encoder-edge and tick items are taken one per cycle while the input is ready and give no result.
// A control update keeps the input not ready until it finishes, and longer when the speed is
// re-estimated (50 ms or more since the last estimate): the estimate runs one
// restoring divider at one quotient bit per cycle, 53 bits in all; the PID step uses
// one shared 33x17 multiplier and a 30x30 reciprocal multiplier for the integral and
// derivative scaling. A finished result waits in an output register, and the update
// holds in its final state while that register is full and not being taken.
`timescale 1ns / 1ps
module encoder_velocity_pid_drive_core (
  input logic       clk,
  input logic       rst,
  evpd_in_if.sink   in_ch,
  evpd_out_if.source out_ch,
  evpd_cfg_if.sink  cfg
);
  import evpd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EMUL  = 4'd1;
  localparam logic [3:0] ST_EDEN  = 4'd2;
  localparam logic [3:0] ST_EDIV  = 4'd3;
  localparam logic [3:0] ST_EWAIT = 4'd4;
  localparam logic [3:0] ST_ERR   = 4'd5;
  localparam logic [3:0] ST_PMUL  = 4'd6;
  localparam logic [3:0] ST_IMUL  = 4'd7;
  localparam logic [3:0] ST_IDIV  = 4'd8;
  localparam logic [3:0] ST_IWAIT = 4'd9;
  localparam logic [3:0] ST_DMUL  = 4'd10;
  localparam logic [3:0] ST_DDIV  = 4'd11;
  localparam logic [3:0] ST_DWAIT = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [GAIN_W-1:0] ticks_per_rev;
  logic              reversed;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;

  logic [31:0]        position_count;
  logic [31:0]        last_position;
  logic [31:0]        elapsed_ms;
  speed_t             speed_estimate;
  logic signed [23:0] integral_sum;
  logic signed [24:0] last_error;
  logic signed [24:0] error;
  speed_t             target;
  logic signed [33:0] p_term;
  logic signed [19:0] d_term;
  logic               num_neg;
  logic [DIV_NUM_W-1:0] num_mag;
  logic signed [49:0] prod;

  logic               in_acc;
  logic [31:0]        delta;
  logic [GAIN_W-1:0]  tpr_eff;
  logic signed [25:0] err_diff;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic               prod_neg;
  logic [49:0]        prod_mag;
  logic [32:0]        p_mag;

  logic                   div_start;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic [DIV_NUM_W-1:0]   quo;

  logic [RECIP_W-1:0]     rcp_a;
  logic [RECIP_W-1:0]     rcp_b;
  logic [2*RECIP_W-1:0]   rcp_prod;
  logic [27:0]            iquo;
  logic [18:0]            dquo;

  speed_t             speed_q;
  logic signed [29:0] int_inc;
  logic signed [30:0] int_new;
  logic signed [23:0] int_clamped;
  logic signed [19:0] d_q;
  logic signed [35:0] sum;
  logic signed [35:0] sum_cl;
  logic               sum_nonneg;
  logic [35:0]        sum_abs;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;

  assign delta    = position_count - last_position;
  assign tpr_eff  = (ticks_per_rev == '0) ? GAIN_W'(1) : ticks_per_rev;
  assign err_diff = {error[24], error} - {last_error[24], last_error};

  always_comb begin
    mul_a = {delta[31], delta};
    mul_b = 17'(SPEED_SCALE);
    case (state)
      ST_EMUL: begin
        mul_a = {delta[31], delta};
        mul_b = 17'(SPEED_SCALE);
      end
      ST_EDEN: begin
        mul_a = {1'b0, elapsed_ms};
        mul_b = {1'b0, tpr_eff};
      end
      ST_PMUL: begin
        mul_a = {{8{error[24]}}, error};
        mul_b = {1'b0, gain_p};
      end
      ST_IMUL: begin
        mul_a = {{8{error[24]}}, error};
        mul_b = {1'b0, gain_i};
      end
      ST_DMUL: begin
        mul_a = {{7{err_diff[25]}}, err_diff};
        mul_b = {1'b0, gain_d};
      end
      default: begin
        mul_a = {delta[31], delta};
        mul_b = 17'(SPEED_SCALE);
      end
    endcase
  end

  assign prod_neg = prod[49];
  assign prod_mag = prod_neg ? 50'(-prod) : 50'(prod);
  assign p_mag    = prod_mag[GAIN_SHIFT+32:GAIN_SHIFT];

  assign div_start = (state == ST_EDIV);
  assign div_num   = num_mag;
  assign div_den   = prod[DIV_DEN_W-1:0];

  evpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // constant scaling by a shift and a reciprocal multiply
  assign rcp_a = (state == ST_DDIV) ? {1'b0, prod_mag[DSCALE_SHIFT+28:DSCALE_SHIFT]}
                                    : prod_mag[ISCALE_SHIFT+29:ISCALE_SHIFT];
  assign rcp_b = (state == ST_DDIV) ? DRECIP : IRECIP;
  assign iquo  = rcp_prod[IRECIP_SHIFT+27:IRECIP_SHIFT];
  assign dquo  = rcp_prod[DRECIP_SHIFT+18:DRECIP_SHIFT];

  // signed quotients with saturation and clamping
  always_comb begin
    if (!num_neg) begin
      speed_q = (quo > DIV_NUM_W'(8388607)) ? speed_t'(24'h7FFFFF) : speed_t'(quo[23:0]);
    end else begin
      speed_q = (quo > DIV_NUM_W'(8388608)) ? speed_t'(24'h800000) : speed_t'(-quo[23:0]);
    end
    int_inc = num_neg ? -$signed({2'b0, iquo}) : $signed({2'b0, iquo});
    int_new = {{7{integral_sum[23]}}, integral_sum} + {int_inc[29], int_inc};
    if (int_new > 31'(OUT_LIMIT)) begin
      int_clamped = 24'(OUT_LIMIT);
    end else if (int_new < -31'(OUT_LIMIT)) begin
      int_clamped = -24'(OUT_LIMIT);
    end else begin
      int_clamped = int_new[23:0];
    end
    d_q = num_neg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
    sum = {{2{p_term[33]}}, p_term} + {{12{integral_sum[23]}}, integral_sum}
        + {{16{d_term[19]}}, d_term};
    if (sum > 36'(OUT_LIMIT)) begin
      sum_cl = 36'(OUT_LIMIT);
    end else if (sum < -36'(OUT_LIMIT)) begin
      sum_cl = -36'(OUT_LIMIT);
    end else begin
      sum_cl = sum;
    end
    sum_nonneg = !sum_cl[35];
    sum_abs    = sum_nonneg ? sum_cl : -sum_cl;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_ch.action == ACT_CONTROL) begin
          state_next = (elapsed_ms >= 32'(WINDOW_MS)) ? ST_EMUL : ST_ERR;
        end
      end
      ST_EMUL:  state_next = ST_EDEN;
      ST_EDEN:  state_next = ST_EDIV;
      ST_EDIV:  state_next = ST_EWAIT;
      ST_EWAIT: state_next = div_done ? ST_ERR : ST_EWAIT;
      ST_ERR:   state_next = ST_PMUL;
      ST_PMUL:  state_next = ST_IMUL;
      ST_IMUL:  state_next = ST_IDIV;
      ST_IDIV:  state_next = ST_IWAIT;
      ST_IWAIT: state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DDIV;
      ST_DDIV:  state_next = ST_DWAIT;
      ST_DWAIT: state_next = ST_FIN;
      ST_FIN:   state_next = (!out_ch.valid || out_ch.ready) ? ST_IDLE : ST_FIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ticks_per_rev  <= GAIN_W'(1);
      reversed       <= 1'b0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      position_count <= '0;
      last_position  <= '0;
      elapsed_ms     <= '0;
      speed_estimate <= '0;
      integral_sum   <= '0;
      last_error     <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_TICKS_PER_REV: ticks_per_rev <= cfg.data;
          CFG_REVERSED:      reversed      <= cfg.data[0];
          CFG_GAIN_P:        gain_p        <= cfg.data;
          CFG_GAIN_I:        gain_i        <= cfg.data;
          CFG_GAIN_D:        gain_d        <= cfg.data;
          default:           reversed      <= reversed;
        endcase
      end
      if (in_acc && in_ch.action == ACT_EDGE) begin
        if ((in_ch.chan_a == in_ch.chan_b) != reversed) begin
          position_count <= position_count + 32'd1;
        end else begin
          position_count <= position_count - 32'd1;
        end
      end
      if (in_acc && in_ch.action == ACT_TICK && elapsed_ms != 32'hFFFF_FFFF) begin
        elapsed_ms <= elapsed_ms + 32'd1;
      end
      if (state == ST_EWAIT && div_done) begin
        speed_estimate <= speed_q;
        elapsed_ms     <= '0;
        last_position  <= position_count;
      end
      if (state == ST_IWAIT) begin
        integral_sum <= int_clamped;
      end
      if (state == ST_FIN && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        last_error   <= error;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_acc) begin
      target <= in_ch.target_speed;
    end
    if (state == ST_EDEN) begin
      num_neg <= prod_neg;
      num_mag <= DIV_NUM_W'(prod_mag) << FRAC_BITS;
    end
    if (state == ST_IDIV || state == ST_DDIV) begin
      num_neg  <= prod_neg;
      rcp_prod <= rcp_a * rcp_b;
    end
    if (state == ST_ERR) begin
      error <= {target[23], target} - {speed_estimate[23], speed_estimate};
    end
    if (state == ST_IMUL) begin
      p_term <= prod_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
    end
    if (state == ST_DWAIT) begin
      d_term <= d_q;
    end
    if (state == ST_FIN && (!out_ch.valid || out_ch.ready)) begin
      out_ch.drive_level    <= sum_abs[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
      out_ch.drive_dir      <= sum_nonneg != reversed;
      out_ch.measured_speed <= speed_estimate;
    end
  end

endmodule

// File: hw/rtl/evpd_div.sv
// restoring divider for the speed estimate, one quotient bit per cycle
`timescale 1ns / 1ps
module evpd_div #(
  parameter int NW = evpd_pkg::DIV_NUM_W,
  parameter int DW = evpd_pkg::DIV_DEN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  import evpd_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   shifted;
  logic          take;

  assign shifted = {rem[DW-1:0], quo[NW-1]};
  assign take    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= take ? (shifted - {1'b0, den_r}) : shifted;
      quo <= {quo[NW-2:0], take};
    end
  end

endmodule

// File: hw/rtl/evpd_checker.sv
// port-level checks for the speed regulator, bound to the top level
`timescale 1ns / 1ps
`include "encoder_velocity_pid_drive_core_defines.svh"
module evpd_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input evpd_pkg::action_t      in_action,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   cfg_ready
);
  import evpd_pkg::*;

  `EVPD_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_valid, "result valid after reset")
  `EVPD_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid, "result dropped")
  `EVPD_ASSERT(a_ctrl_busy, in_valid && in_ready && in_action == ACT_CONTROL |=> !in_ready, "input ready during update")
  `EVPD_ASSERT(a_cfg_ready, cfg_ready, "config port stalled")

endmodule

bind encoder_velocity_pid_drive_core evpd_checker u_evpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg.ready)
);
